/* hdl/sha_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sha_pkg;

    typedef logic [31:0]      word_t;
    typedef logic [7:0][31:0] hash_t;

    // Controls of the message schedule window.
    typedef struct packed {
        logic load;   // shift in a message word
        logic step;   // shift in an expanded schedule word
    } sched_ctrl_t;

    // Controls of the round datapath.
    typedef struct packed {
        logic init;   // load working variables from the chaining hash
        logic step;   // run one compression round
    } round_ctrl_t;

    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned BLOCK_WORDS = 16;

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t r;
        case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            3'd7: r = 32'h5be0cd19;
            default: r = 32'h6a09e667;
        endcase
        return r;
    endfunction

    function automatic word_t round_k(input logic [5:0] idx);
        word_t r;
        case (idx)
            6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
            default: r = 32'h428a2f98;
        endcase
        return r;
    endfunction

    function automatic word_t small_s0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_s1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    function automatic word_t big_s0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_s1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

endpackage

`default_nettype wire

/* hdl/sha_msg_sched.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sixteen-word schedule window kept as a shift line; tap 0 is the oldest word.
module sha_msg_sched (
    input  wire logic                 aclk,
    input  wire sha_pkg::sched_ctrl_t ctrl,
    input  wire sha_pkg::word_t       msg_word,
    output sha_pkg::word_t            sched_word
);

    sha_pkg::word_t win_reg [sha_pkg::BLOCK_WORDS];
    sha_pkg::word_t expand_word;

    // W[t+16] from W[t+14], W[t+9], W[t+1] and W[t].
    assign expand_word = sha_pkg::small_s1(win_reg[14]) + win_reg[9]
                       + sha_pkg::small_s0(win_reg[1]) + win_reg[0];

    assign sched_word = win_reg[0];

    always_ff @(posedge aclk) begin
        if (ctrl.load || ctrl.step) begin
            for (int i = 0; i < sha_pkg::BLOCK_WORDS - 1; i++) begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[sha_pkg::BLOCK_WORDS - 1] <= ctrl.load ? msg_word : expand_word;
        end
    end

endmodule

`default_nettype wire

/* hdl/sha_round.sv */
`timescale 1ns / 1ps
`default_nettype none

// Working variables a..h and the single round unit used for all 64 rounds.
module sha_round (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire sha_pkg::round_ctrl_t ctrl,
    input  wire sha_pkg::hash_t       chain,
    input  wire sha_pkg::word_t       sched_word,
    input  wire logic [5:0]           round_idx,
    output sha_pkg::hash_t            vars
);

    sha_pkg::hash_t v_reg;
    sha_pkg::word_t t1;
    sha_pkg::word_t t2;
    sha_pkg::word_t ch;
    sha_pkg::word_t maj;

    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + sha_pkg::big_s1(v_reg[4]) + ch
               + sha_pkg::round_k(round_idx) + sched_word;
    assign t2  = sha_pkg::big_s0(v_reg[0]) + maj;

    assign vars = v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ctrl.init) begin
            v_reg <= chain;
        end else if (ctrl.step) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule

`default_nettype wire

/* hdl/sha256_block_compress_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload                                   Handshake
// s_        in         s_msg_word[31:0], s_start_message         s_valid / s_ready
// m_        out        m_digest_word[31:0], m_word_index[2:0],   m_valid / m_ready
//                      m_last_word
//
// A message word request is accepted whenever the block is loading. The
// sixteenth word of a block starts 64 rounds on the shared round unit, one per
// cycle, then the ST_FIN state adds the working variables into the chaining
// hash, and the block stays busy through the 8 digest word requests, which
// wait as long as m_ready stays low. Reset (aresetn, synchronous, active
// low) loads the standard initial hash and returns the sequencer to the
// loading state.
module sha256_block_compress_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_msg_word,
    input  wire logic        s_start_message,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_word_index,
    output logic             m_last_word
);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_FIN   = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [3:0]           word_cnt_reg, word_cnt_next;
    logic [5:0]           round_reg, round_next;
    logic [2:0]           out_idx_reg, out_idx_next;
    sha_pkg::hash_t       chain_reg;
    sha_pkg::hash_t       vars;
    sha_pkg::word_t       sched_word;
    sha_pkg::sched_ctrl_t sched_ctrl;
    sha_pkg::round_ctrl_t round_ctrl;
    logic                 in_fire;
    logic                 out_fire;
    logic [3:0]           word_pos;
    logic                 block_done;

    assign s_ready  = (state_reg == ST_LOAD);
    assign in_fire  = s_valid && s_ready;
    assign m_valid  = (state_reg == ST_OUT);
    assign out_fire = m_valid && m_ready;

    // A start request discards any partial block and becomes word 0.
    assign word_pos   = s_start_message ? 4'd0 : word_cnt_reg;
    assign block_done = in_fire && (word_pos == 4'(sha_pkg::BLOCK_WORDS - 1));

    assign sched_ctrl.load = in_fire;
    assign sched_ctrl.step = (state_reg == ST_ROUND);
    assign round_ctrl.init = block_done;
    assign round_ctrl.step = (state_reg == ST_ROUND);

    assign m_digest_word = chain_reg[out_idx_reg];
    assign m_word_index  = out_idx_reg;
    assign m_last_word   = (out_idx_reg == 3'd7);

    sha_msg_sched u_sched (
        .aclk       (aclk),
        .ctrl       (sched_ctrl),
        .msg_word   (s_msg_word),
        .sched_word (sched_word)
    );

    sha_round u_round (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (round_ctrl),
        .chain      (chain_reg),
        .sched_word (sched_word),
        .round_idx  (round_reg),
        .vars       (vars)
    );

    always_comb begin
        state_next    = state_reg;
        word_cnt_next = word_cnt_reg;
        round_next    = round_reg;
        out_idx_next  = out_idx_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_fire) begin
                    // Wraps to zero after the sixteenth word.
                    word_cnt_next = word_pos + 4'd1;
                    if (block_done) begin
                        state_next = ST_ROUND;
                        round_next = '0;
                    end
                end
            end
            ST_ROUND: begin
                round_next = round_reg + 6'd1;
                if (round_reg == 6'(sha_pkg::NUM_ROUNDS - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                state_next   = ST_OUT;
                out_idx_next = '0;
            end
            ST_OUT: begin
                if (out_fire) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'd7) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            word_cnt_reg <= '0;
            round_reg    <= '0;
            out_idx_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            word_cnt_reg <= word_cnt_next;
            round_reg    <= round_next;
            out_idx_reg  <= out_idx_next;
        end
    end

    // The chaining hash is reloaded by a start request and accumulates the
    // final working variables once the rounds of a block are done.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= sha_pkg::init_hash(3'(i));
            end
        end else if (in_fire && s_start_message) begin
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= sha_pkg::init_hash(3'(i));
            end
        end else if (state_reg == ST_FIN) begin
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= chain_reg[i] + vars[i];
            end
        end
    end

endmodule

`default_nettype wire
